// ----- rtl/alstep_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alstep_pkg
// Shared types and constants of the antialiased line stepper.
// ----------------------------------------------------------------------------
package alstep_pkg;

  localparam int SUB_BITS    = 4;
  localparam int POS_W       = 14;
  localparam int COVER_W     = 8;
  localparam int S_TDATA_W   = 8;
  localparam int M_TDATA_W   = 4 * POS_W + 2 * COVER_W;
  localparam int CFG_INDEX_W = 8;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_START_X = 8'd0,
    REG_START_Y = 8'd1,
    REG_END_X   = 8'd2,
    REG_END_Y   = 8'd3
  } cfg_reg_t;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_DIV  = 6'b000010,
    ST_GRAD = 6'b000100,
    ST_SEED = 6'b001000,
    ST_EMIT = 6'b010000,
    ST_OUT  = 6'b100000
  } state_t;

  typedef struct packed {
    logic setup;
    logic div_step;
    logic grad_load;
    logic seed_load;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic active;
    logic div_last;
  } status_t;

endpackage

// ----- rtl/alstep_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alstep_ctrl
// Sequencer for line setup, gradient division and pixel pair emission.
// ----------------------------------------------------------------------------
module alstep_ctrl
  import alstep_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  logic    in_restart,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_restart) begin
            cmd.setup  = 1'b1;
            state_next = ST_DIV;
          end else if (status.active) begin
            cmd.emit   = 1'b1;
            state_next = ST_OUT;
          end
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = ST_GRAD;
        end
      end
      ST_GRAD: begin
        cmd.grad_load = 1'b1;
        state_next    = ST_SEED;
      end
      ST_SEED: begin
        cmd.seed_load = 1'b1;
        state_next    = ST_EMIT;
      end
      ST_EMIT: begin
        cmd.emit   = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/alstep_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alstep_dp
// Endpoint registers, setup, restoring divider, minor accumulator and the
// registered pixel pair.
// ----------------------------------------------------------------------------
module alstep_dp
  import alstep_pkg::*;
#(
  parameter int COORD_BITS     = 12,
  parameter int GRAD_FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [CFG_INDEX_W-1:0]        cfg_index,
  input  logic [COORD_BITS+SUB_BITS-1:0] cfg_data,
  input  cmd_t                          cmd,
  output status_t                       status,
  output logic [POS_W-1:0]              lo_x,
  output logic [POS_W-1:0]              lo_y,
  output logic [POS_W-1:0]              hi_x,
  output logic [POS_W-1:0]              hi_y,
  output logic [COVER_W-1:0]            cover_lo,
  output logic [COVER_W-1:0]            cover_hi,
  output logic                          last
);

  localparam int R     = COORD_BITS + SUB_BITS;
  localparam int G     = GRAD_FRAC_BITS;
  localparam int A     = COORD_BITS + G + 2;
  localparam int CNT_W = $clog2(G + 1);

  logic [R-1:0] start_x;
  logic [R-1:0] start_y;
  logic [R-1:0] end_x;
  logic [R-1:0] end_y;

  logic                steep;
  logic [R-1:0]        y0_r;
  logic [R-1:0]        dx_r;
  logic                dy_neg;
  logic                dx_zero;
  logic                ady_lsb;
  logic [COORD_BITS-1:0] x0_major;
  logic [COORD_BITS-1:0] x1_major;

  logic [R-1:0]     rem;
  logic [G:0]       quo;
  logic [CNT_W-1:0] cnt;

  logic signed [G+1:0] gradient;
  logic signed [A-1:0] minor_acc;
  logic [COORD_BITS:0] major_pos;
  logic [COORD_BITS-1:0] major_end;
  logic                active;
  logic                steep_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_x <= '0;
      start_y <= '0;
      end_x   <= '0;
      end_y   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_START_X: start_x <= cfg_data;
        REG_START_Y: start_y <= cfg_data;
        REG_END_X:   end_x   <= cfg_data;
        REG_END_Y:   end_y   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Line setup: pick the major axis and order the ends along it.
  logic signed [R:0] dxs;
  logic signed [R:0] dys;
  logic signed [R:0] major_d;
  logic signed [R:0] minor_d;
  logic [R-1:0]      adx;
  logic [R-1:0]      ady;
  logic              steep_c;
  logic              swap_c;
  logic [R-1:0]      a0;
  logic [R-1:0]      a1;
  logic [R-1:0]      b0;
  logic [R-1:0]      b1;
  logic [R-1:0]      dx_c;
  logic [R-1:0]      ady_c;

  always_comb begin
    dxs     = $signed({1'b0, end_x}) - $signed({1'b0, start_x});
    dys     = $signed({1'b0, end_y}) - $signed({1'b0, start_y});
    adx     = dxs[R] ? R'(-dxs) : dxs[R-1:0];
    ady     = dys[R] ? R'(-dys) : dys[R-1:0];
    steep_c = ady > adx;
    major_d = steep_c ? dys : dxs;
    minor_d = steep_c ? dxs : dys;
    swap_c  = major_d[R];
    a0      = steep_c ? start_y : start_x;
    a1      = steep_c ? end_y   : end_x;
    b0      = steep_c ? start_x : start_y;
    b1      = steep_c ? end_x   : end_y;
    dx_c    = steep_c ? ady : adx;
    ady_c   = steep_c ? adx : ady;
  end

  // Restoring divider, one quotient bit per step.
  logic [R:0] trial;
  logic [R:0] diff;
  logic       ge;

  always_comb begin
    trial = {rem, (cnt == '0) ? ady_lsb : 1'b0};
    diff  = trial - {1'b0, dx_r};
    ge    = trial >= {1'b0, dx_r};
  end

  assign status.div_last = cnt == CNT_W'(G);
  assign status.active   = active;

  // Pixel pair from the current minor coordinate.
  logic signed [COORD_BITS+1:0] iy;
  logic signed [COORD_BITS+2:0] iy_p1;
  logic [G-1:0]                 frac;
  logic [G:0]                   inv;
  logic [G+7:0]                 prod_hi;
  logic [G+8:0]                 prod_lo;
  logic [POS_W-1:0]             iy_pos;
  logic [POS_W-1:0]             iy1_pos;
  logic [POS_W-1:0]             mj_pos;
  logic                         is_last;

  always_comb begin
    iy      = $signed(minor_acc[A-1:G]);
    iy_p1   = {iy[COORD_BITS+1], iy} + 1'sb1;
    frac    = minor_acc[G-1:0];
    inv     = {1'b1, {G{1'b0}}} - {1'b0, frac};
    prod_hi = {frac, 8'd0} - {8'd0, frac};
    prod_lo = {inv, 8'd0} - {8'd0, inv};
    iy_pos  = POS_W'(iy);
    iy1_pos = POS_W'(iy_p1);
    mj_pos  = POS_W'(major_pos);
    is_last = major_pos >= {1'b0, major_end};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active     <= 1'b0;
      steep_mode <= 1'b0;
      major_pos  <= '0;
      major_end  <= '0;
      minor_acc  <= '0;
      gradient   <= '0;
      cnt        <= '0;
    end else begin
      if (cmd.setup) begin
        steep    <= steep_c;
        y0_r     <= swap_c ? b1 : b0;
        x0_major <= swap_c ? a1[R-1:SUB_BITS] : a0[R-1:SUB_BITS];
        x1_major <= swap_c ? a0[R-1:SUB_BITS] : a1[R-1:SUB_BITS];
        dx_r     <= dx_c;
        dx_zero  <= dx_c == '0;
        dy_neg   <= (minor_d != '0) && (minor_d[R] != swap_c);
        ady_lsb  <= ady_c[0];
        rem      <= {1'b0, ady_c[R-1:1]};
        quo      <= '0;
        cnt      <= '0;
      end
      if (cmd.div_step) begin
        rem <= ge ? diff[R-1:0] : trial[R-1:0];
        quo <= {quo[G-1:0], ge};
        cnt <= cnt + 1'b1;
      end
      if (cmd.grad_load) begin
        if (dx_zero) begin
          gradient <= {2'b01, {G{1'b0}}};
        end else if (dy_neg) begin
          gradient <= -$signed({1'b0, quo});
        end else begin
          gradient <= $signed({1'b0, quo});
        end
      end
      if (cmd.seed_load) begin
        minor_acc  <= $signed({2'b00, y0_r, {(G - SUB_BITS){1'b0}}})
                    + $signed({{(A - G - 1){gradient[G+1]}}, gradient[G+1:1]});
        major_pos  <= {1'b0, x0_major};
        major_end  <= x1_major;
        steep_mode <= steep;
        active     <= 1'b1;
      end
      if (cmd.emit) begin
        if (is_last) begin
          active <= 1'b0;
        end else begin
          major_pos <= major_pos + 1'b1;
          minor_acc <= minor_acc + $signed({{(A - G - 2){gradient[G+1]}}, gradient});
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (steep_mode) begin
        lo_x <= iy_pos;
        lo_y <= mj_pos;
        hi_x <= iy1_pos;
        hi_y <= mj_pos;
      end else begin
        lo_x <= mj_pos;
        lo_y <= iy_pos;
        hi_x <= mj_pos;
        hi_y <= iy1_pos;
      end
      cover_lo <= prod_lo[G+7:G];
      cover_hi <= prod_hi[G+7:G];
      last     <= is_last;
    end
  end

endmodule

// ----- rtl/antialiased_line_stepper_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// antialiased_line_stepper_core
// Wu-style antialiased line stepper: one pixel pair per restart, or per advance while a line is active.
// ----------------------------------------------------------------------------
// A restart shows its pair after the setup step, the restoring gradient
// divider (one quotient bit per cycle), the gradient load, the seed load and
// the emit step. An advance shows its pair in the cycle after it is accepted,
// and new input can follow in the cycle after the result is taken.
// Reset clears the endpoint registers and ends any line in progress.
module antialiased_line_stepper_core
  import alstep_pkg::*;
#(
  parameter int COORD_BITS     = 12,
  parameter int GRAD_FRAC_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [S_TDATA_W-1:0]            s_tdata,   // restart
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [M_TDATA_W-1:0]            m_tdata,   // lo_x, lo_y, hi_x, hi_y, cover_lo, cover_hi
  output logic                            m_tlast,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [CFG_INDEX_W-1:0]          cfg_index,
  input  logic [COORD_BITS+SUB_BITS-1:0]  cfg_data
);

  cmd_t              cmd;
  status_t           status;
  logic [POS_W-1:0]  lo_x;
  logic [POS_W-1:0]  lo_y;
  logic [POS_W-1:0]  hi_x;
  logic [POS_W-1:0]  hi_y;
  logic [COVER_W-1:0] cover_lo;
  logic [COVER_W-1:0] cover_hi;

  assign cfg_ready = 1'b1;
  assign m_tdata   = {cover_hi, cover_lo, hi_y, hi_x, lo_y, lo_x};

  alstep_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_restart (s_tdata[0]),
    .in_ready   (s_tready),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .status     (status),
    .cmd        (cmd)
  );

  alstep_dp #(
    .COORD_BITS     (COORD_BITS),
    .GRAD_FRAC_BITS (GRAD_FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .lo_x      (lo_x),
    .lo_y      (lo_y),
    .hi_x      (hi_x),
    .hi_y      (hi_y),
    .cover_lo  (cover_lo),
    .cover_hi  (cover_hi),
    .last      (m_tlast)
  );

endmodule

// ----- rtl/alstep_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alstep_checker
// Port-level checks of the line stepper, bound to the top level.
// ----------------------------------------------------------------------------
module alstep_checker
  import alstep_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 s_tvalid,
  input logic                 s_tready,
  input logic [S_TDATA_W-1:0] s_tdata,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [M_TDATA_W-1:0] m_tdata,
  input logic                 m_tlast
);

  // A stalled result holds its payload.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled result changed");

  // The stepper never takes input while a result is pending.
  assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input accepted while result pending");

  // A restart needs the divider, so no result and no input in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tdata[0] |=> !m_tvalid && !s_tready)
    else $error("restart finished too early");

  // After a result transaction the stepper is ready for input again.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready |=> s_tready && !m_tvalid)
    else $error("not idle after result");

endmodule

bind antialiased_line_stepper_core alstep_checker u_alstep_checker (.*);
